FILE: rtl/core/lsr_pkg.sv
package lsr_pkg;

    // LIN header and frame constants
    localparam logic [7:0]  SYNC_BYTE     = 8'h55;
    localparam logic [3:0]  NODE_ID_RESET = 4'd12;
    localparam logic [19:0] FREQ_DIVIDEND = 20'd1000000;
    localparam int          DIV_STEPS     = 20;
    localparam int          DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int          REPLY_DEPTH   = 5;
    localparam int          POS_W         = 3;

    // frame selector: bits 5:4 of the identifier
    localparam logic [1:0] SEL_NONE = 2'b00;
    localparam logic [1:0] SEL_TEMP = 2'b01;
    localparam logic [1:0] SEL_FREQ = 2'b10;
    localparam logic [1:0] SEL_KEYS = 2'b11;

    typedef struct packed {
        logic        break_seen;
        logic        byte_received;
        logic        send_done;
        logic [7:0]  rx_byte;
        logic [15:0] temperature;
        logic [15:0] period_ticks;
        logic [15:0] key_state;
    } lsr_in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
    } lsr_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic sum_step;
        logic emit_first;
        logic emit_next;
    } lsr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic brk;
        logic txd;
        logic is_sync;
        logic id_hit;
        logic sel_freq;
        logic div_last;
        logic sum_last;
        logic pos_zero;
        logic out_free;
    } lsr_sts_t;

endpackage

FILE: rtl/core/lsr_datapath.sv
module lsr_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  lsr_pkg::lsr_in_t in_data,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_wdata,
    input  lsr_pkg::lsr_cmd_t cmd,
    output lsr_pkg::lsr_sts_t sts,
    output logic             out_valid,
    input  logic             out_ready,
    output lsr_pkg::lsr_out_t out_data
);
    import lsr_pkg::*;

    logic [3:0]           node_id_reg;
    logic [7:0]           bytes_reg [REPLY_DEPTH];
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     sum_idx_reg, sum_idx_next;
    logic [7:0]           acc_reg, acc_next;
    logic [15:0]          rem_reg, rem_next;
    logic [19:0]          quot_reg, quot_next;
    logic [15:0]          divisor_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    lsr_out_t             out_data_reg;

    logic [5:0]       ident;
    logic [1:0]       sel;
    logic [16:0]      rem_shift;
    logic [16:0]      rem_diff;
    logic             q_bit;
    logic [19:0]      freq;
    logic [POS_W-1:0] pos_dec;
    logic [POS_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic [8:0]       sum_wide;

    // decode the identifier byte
    assign ident = in_data.rx_byte[5:0];
    assign sel   = ident[5:4];

    // one restoring division step per cycle
    assign rem_shift = {rem_reg, quot_reg[19]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign q_bit     = (rem_shift >= {1'b0, divisor_reg});
    assign rem_next  = q_bit ? rem_diff[15:0] : rem_shift[15:0];
    assign quot_next = {quot_reg[18:0], q_bit};
    assign freq      = (divisor_reg == 16'd0) ? 20'd0 : quot_next;

    // select the reply entry to read
    assign pos_dec = pos_reg - POS_W'(1);
    always_comb
    begin
        if (cmd.sum_step)
            rd_addr = sum_idx_reg;
        else if (cmd.emit_first)
            rd_addr = pos_reg;
        else
            rd_addr = pos_dec;
    end
    assign rd_data = bytes_reg[rd_addr];

    // end-around-carry add of one data byte
    assign sum_wide = {1'b0, acc_reg} + {1'b0, rd_data};

    // next values of position, checksum and divider control
    always_comb
    begin
        pos_next     = pos_reg;
        sum_idx_next = sum_idx_reg;
        acc_next     = acc_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.load)
        begin
            sum_idx_next = POS_W'(1);
            acc_next     = {2'b00, sel, node_id_reg};
            div_cnt_next = '0;
            pos_next     = (sel == SEL_FREQ) ? POS_W'(4) : POS_W'(2);
        end
        if (cmd.div_step)
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        if (cmd.sum_step)
        begin
            sum_idx_next = sum_idx_reg + POS_W'(1);
            acc_next     = sum_wide[8] ? (sum_wide[7:0] + 8'd1) : sum_wide[7:0];
        end
        if (cmd.emit_next)
            pos_next = pos_dec;
    end

    // output slot: set on emit, drop when taken
    always_comb
    begin
        if (cmd.emit_first || cmd.emit_next)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg   <= NODE_ID_RESET;
            pos_reg       <= '0;
            sum_idx_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                node_id_reg <= cfg_wdata;
            pos_reg       <= pos_next;
            sum_idx_reg   <= sum_idx_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture reply data, run divider, load output beat
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.load)
        begin
            rem_reg     <= '0;
            quot_reg    <= FREQ_DIVIDEND;
            divisor_reg <= in_data.period_ticks;
            case (sel)
                SEL_TEMP:
                begin
                    bytes_reg[2] <= in_data.temperature[7:0];
                    bytes_reg[1] <= in_data.temperature[15:8];
                end
                SEL_KEYS:
                begin
                    bytes_reg[2] <= in_data.key_state[15:8];
                    bytes_reg[1] <= in_data.key_state[7:0];
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            if (sts.div_last)
            begin
                bytes_reg[4] <= 8'h00;
                bytes_reg[3] <= {4'h0, freq[19:16]};
                bytes_reg[2] <= freq[15:8];
                bytes_reg[1] <= freq[7:0];
            end
        end
        if (cmd.emit_first)
        begin
            bytes_reg[0]            <= ~acc_reg;
            out_data_reg.tx_byte    <= rd_data;
            out_data_reg.frame_last <= 1'b0;
        end
        if (cmd.emit_next)
        begin
            out_data_reg.tx_byte    <= rd_data;
            out_data_reg.frame_last <= (pos_dec == '0);
        end
    end

    // status to the controller
    assign sts.brk      = in_data.break_seen;
    assign sts.txd      = in_data.send_done;
    assign sts.is_sync  = in_data.byte_received && (in_data.rx_byte == SYNC_BYTE);
    assign sts.id_hit   = in_data.byte_received && (ident[3:0] == node_id_reg)
                          && (sel != SEL_NONE);
    assign sts.sel_freq = (sel == SEL_FREQ);
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.sum_last = (sum_idx_reg == pos_reg);
    assign sts.pos_zero = (pos_reg == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the first beat of a reply is never the checksum
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_first |=> out_valid && !out_data.frame_last)
        else $error("first reply beat flagged as checksum");

    // a checksum beat leaves the position at zero
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_next |=> (out_data.frame_last == (pos_reg == '0)))
        else $error("checksum flag out of step with reply position");

endmodule

FILE: rtl/core/lsr_ctrl.sv
module lsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsr_pkg::lsr_sts_t sts,
    output lsr_pkg::lsr_cmd_t cmd
);
    import lsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BREAK,
        ST_SYNC,
        ST_RESP,
        ST_DIV,
        ST_SUM,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   accepting;
    logic   acc;

    // take beats only in the link phases, with the output slot free
    always_comb
    begin
        case (state_reg)
            ST_IDLE, ST_BREAK, ST_SYNC, ST_RESP: accepting = 1'b1;
            default:                             accepting = 1'b0;
        endcase
    end
    assign in_ready = accepting && sts.out_free;
    assign acc      = in_valid && in_ready;

    // advance the link phase and the reply build sequence
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && sts.brk)
                    state_next = ST_BREAK;
            end
            ST_BREAK:
            begin
                if (acc)
                    state_next = sts.is_sync ? ST_SYNC : ST_IDLE;
            end
            ST_SYNC:
            begin
                if (acc)
                begin
                    if (sts.id_hit)
                    begin
                        cmd.load   = 1'b1;
                        state_next = sts.sel_freq ? ST_DIV : ST_SUM;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_first = 1'b1;
                    state_next     = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (acc && sts.txd)
                begin
                    if (sts.pos_zero)
                        state_next = ST_IDLE;
                    else
                        cmd.emit_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // the divider runs without interruption until its last step
    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && !sts.div_last |=> state_reg == ST_DIV)
        else $error("divider sequence left early");

    // the output slot is always free when the first reply beat is due
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> sts.out_free)
        else $error("first reply beat blocked by pending output");

    // a reply build is started only from the sync phase
    a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIV) || (state_reg == ST_SUM))
        else $error("reply build entered from wrong phase");

endmodule

FILE: rtl/core/lin_slave_responder.sv
// LIN slave responder: header tracking and reply generation.
// One beat a cycle is taken in a link phase unless a reply byte waits at the output. A
// matching identifier starts a reply: temperature and key frames build the checksum, then
// the first byte goes out; the frequency frame first runs the 20-step divider. Later reply
// bytes appear the cycle after each send_done beat until the checksum has gone out.
// rst_n is asynchronous, active low: link goes idle, node id returns to 12.
module lin_slave_responder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsr_pkg::lsr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lsr_pkg::lsr_out_t out_data,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_wdata
);
    import lsr_pkg::*;

    lsr_cmd_t cmd;
    lsr_sts_t sts;

    // sequence the link phases and reply build
    lsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold reply bytes, divider, checksum and output beat
    lsr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: bench/lin_slave_responder_tb.sv
`timescale 1ns / 100ps

module lin_slave_responder_tb;

    import lsr_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DIRECTED_END  = 40;
    localparam int SWEEP_END     = 320;
    localparam int RANDOM_END    = 830;
    localparam int TOTAL_BEATS   = 950;

    typedef enum logic [1:0] {
        LINK_IDLE  = 2'd0,
        LINK_BREAK = 2'd1,
        LINK_SYNC  = 2'd2,
        LINK_RESP  = 2'd3
    } link_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    lsr_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    lsr_out_t out_data;
    logic     cfg_we;
    logic [3:0] cfg_wdata;

    // predictor state
    link_t      link_ph;
    logic [7:0] reply_mem [0:REPLY_DEPTH-1];
    int         reply_pos;
    logic [3:0] node_q;

    lsr_out_t   expected_tx [$];
    lsr_out_t   want;
    int         fails;
    int         beats_sent;
    int         idle_cycles;
    int         stall_left;
    bit         idling;

    lin_slave_responder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // inverted end-around-carry sum over data entries 1..count
    function automatic logic [7:0] frame_checksum(input logic [5:0] ident, input int count);
        logic [8:0] acc;
        acc = {3'b000, ident};
        for (int k = 1; k <= count; k++)
        begin
            acc = acc + {1'b0, reply_mem[k]};
            if (acc[8])
            begin
                acc = {1'b0, acc[7:0]} + 9'd1;
            end
        end
        return ~acc[7:0];
    endfunction

    // advance the link state by one accepted beat and queue any reply byte
    task automatic predict_reply(input lsr_in_t b);
        logic [5:0]  ident;
        logic [31:0] freq;
        lsr_out_t    o;
        case (link_ph)
            LINK_IDLE:
            begin
                if (b.break_seen)
                begin
                    link_ph = LINK_BREAK;
                end
            end
            LINK_BREAK:
            begin
                if (b.byte_received && b.rx_byte == SYNC_BYTE)
                begin
                    link_ph = LINK_SYNC;
                end
                else
                begin
                    link_ph = LINK_IDLE;
                end
            end
            LINK_SYNC:
            begin
                link_ph = LINK_IDLE;
                ident = b.rx_byte[5:0];
                if (b.byte_received && ident[3:0] == node_q && ident[5:4] != SEL_NONE)
                begin
                    case (ident[5:4])
                        SEL_TEMP:
                        begin
                            reply_mem[2] = b.temperature[7:0];
                            reply_mem[1] = b.temperature[15:8];
                            reply_pos = 2;
                        end
                        SEL_FREQ:
                        begin
                            if (b.period_ticks != 16'd0)
                            begin
                                freq = 32'(FREQ_DIVIDEND) / 32'(b.period_ticks);
                            end
                            else
                            begin
                                freq = 32'd0;
                            end
                            reply_mem[4] = freq[31:24];
                            reply_mem[3] = freq[23:16];
                            reply_mem[2] = freq[15:8];
                            reply_mem[1] = freq[7:0];
                            reply_pos = 4;
                        end
                        default:
                        begin
                            reply_mem[2] = b.key_state[15:8];
                            reply_mem[1] = b.key_state[7:0];
                            reply_pos = 2;
                        end
                    endcase
                    reply_mem[0] = frame_checksum(ident, reply_pos);
                    link_ph = LINK_RESP;
                    o.tx_byte = reply_mem[reply_pos];
                    o.frame_last = 1'b0;
                    expected_tx.push_back(o);
                end
            end
            default:
            begin
                if (b.send_done)
                begin
                    if (reply_pos == 0)
                    begin
                        link_ph = LINK_IDLE;
                    end
                    else
                    begin
                        reply_pos = reply_pos - 1;
                        o.tx_byte = reply_mem[reply_pos];
                        o.frame_last = (reply_pos == 0);
                        expected_tx.push_back(o);
                    end
                end
            end
        endcase
    endtask

    // period values weighted toward zero, one and the extremes
    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(2, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic lsr_in_t lin_beat(input logic brk, input logic rxv, input logic txd,
                                         input logic [7:0] rxb);
        lsr_in_t b;
        b.break_seen    = brk;
        b.byte_received = rxv;
        b.send_done     = txd;
        b.rx_byte       = rxb;
        b.temperature   = 16'($urandom);
        b.period_ticks  = pick_period();
        b.key_state     = 16'($urandom);
        return b;
    endfunction

    // drive one beat at the falling edge, hold until accepted
    task automatic send_beat(input lsr_in_t b);
        int gap;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_reply(b);
        beats_sent++;
    endtask

    // bring the link back to idle: finish a reply or drop a partial header
    task automatic return_to_idle();
        while (link_ph == LINK_RESP)
        begin
            send_beat(lin_beat(1'($urandom), 1'($urandom), 1'b1, 8'($urandom)));
        end
        if (link_ph != LINK_IDLE)
        begin
            send_beat(lin_beat(1'b0, 1'b0, 1'($urandom), 8'($urandom)));
        end
    endtask

    // header plus identifier, then send_done beats until the reply is over
    task automatic send_frame(input logic [7:0] id_byte, input logic [15:0] temp,
                              input logic [15:0] per, input logic [15:0] keys);
        lsr_in_t b;
        return_to_idle();
        send_beat(lin_beat(1'b1, 1'($urandom), 1'($urandom), 8'($urandom)));
        send_beat(lin_beat(1'($urandom), 1'b1, 1'($urandom), SYNC_BYTE));
        b = lin_beat(1'($urandom), 1'b1, 1'($urandom), id_byte);
        b.temperature  = temp;
        b.period_ticks = per;
        b.key_state    = keys;
        send_beat(b);
        while (link_ph == LINK_RESP)
        begin
            // mix in beats the responder must ignore
            if ($urandom_range(0, 4) == 0)
            begin
                send_beat(lin_beat(1'($urandom), 1'($urandom), 1'b0, 8'($urandom)));
            end
            else
            begin
                send_beat(lin_beat(1'($urandom), 1'($urandom), 1'b1, 8'($urandom)));
            end
        end
    endtask

    task automatic random_frame();
        logic [1:0] sel;
        logic [3:0] nd;
        sel = ($urandom_range(0, 9) == 0) ? SEL_NONE : 2'($urandom_range(1, 3));
        nd  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : node_q;
        send_frame({2'($urandom), sel, nd}, 16'($urandom), pick_period(), 16'($urandom));
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            send_beat(lin_beat(1'($urandom), 1'($urandom), 1'($urandom),
                               $urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom)));
        end
    endtask

    task automatic run_traffic(input int until_beats);
        while (beats_sent < until_beats)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                random_frame();
            end
            else
            begin
                noise_burst();
            end
        end
    endtask

    // drop valid, wait for every reply byte, then let the datapath settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tx.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_node(input logic [3:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        node_q = v;
    endtask

    // every frame type, identifier corner cases and broken headers at reset node id
    task automatic test_directed();
        send_frame(8'h1C, 16'hFFFF, 16'd100, 16'h1234);
        send_frame(8'h2C, 16'h0000, 16'd1, 16'hFFFF);
        send_frame(8'h2C, 16'hA5A5, 16'hFFFF, 16'h0000);
        send_frame(8'h3C, 16'h0000, 16'd0, 16'h0000);
        send_frame(8'hFC, 16'h5A5A, 16'd7, 16'hFFFF);
        send_frame(8'hEC, 16'h0001, 16'd0, 16'h8000);
        send_frame(8'h1D, 16'hFFFF, 16'd1, 16'hFFFF);
        send_frame(8'hCC, 16'hFFFF, 16'd1, 16'hFFFF);
        send_beat(lin_beat(1'b1, 1'b0, 1'b0, 8'h00));
        send_beat(lin_beat(1'b0, 1'b1, 1'b0, 8'h54));
        send_beat(lin_beat(1'b1, 1'b0, 1'b0, 8'h00));
        send_beat(lin_beat(1'b0, 1'b0, 1'b1, SYNC_BYTE));
        send_beat(lin_beat(1'b0, 1'b1, 1'b1, SYNC_BYTE));
        drain();
    endtask

    // extreme, random and reset node ids, each with random frames
    task automatic test_node_sweep();
        logic [3:0] nodes [0:3];
        nodes[0] = 4'd0;
        nodes[1] = 4'd15;
        nodes[2] = 4'($urandom);
        nodes[3] = NODE_ID_RESET;
        for (int i = 0; i < 4; i++)
        begin
            set_node(nodes[i]);
            run_traffic(DIRECTED_END + (i + 1) * (SWEEP_END - DIRECTED_END) / 4);
            drain();
        end
    endtask

    // long random run, node id changed between phases
    task automatic test_random_traffic();
        while (beats_sent < RANDOM_END)
        begin
            set_node(4'($urandom));
            run_traffic(beats_sent + 120);
            drain();
        end
    endtask

    // full throughput on both sides to the end
    task automatic test_full_rate();
        idling = 1'b0;
        set_node(4'($urandom));
        run_traffic(TOTAL_BEATS);
        drain();
    endtask

    // output side: random stall bursts, always ready once idling is cleared
    always @(negedge clk)
    begin
        if (!idling)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // check each reply beat against the oldest expected byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tx.size() == 0)
            begin
                $error("unexpected reply beat tx_byte=%h frame_last=%b",
                       out_data.tx_byte, out_data.frame_last);
                fails++;
            end
            else
            begin
                want = expected_tx.pop_front();
                if (out_data.tx_byte !== want.tx_byte)
                begin
                    $error("tx_byte expected %h actual %h", want.tx_byte, out_data.tx_byte);
                    fails++;
                end
                if (out_data.frame_last !== want.frame_last)
                begin
                    $error("frame_last expected %b actual %b",
                           want.frame_last, out_data.frame_last);
                    fails++;
                end
            end
        end
    end

    // end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b1;
        cfg_we      = 1'b0;
        cfg_wdata   = 4'd0;
        fails       = 0;
        beats_sent  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        idling      = 1'b1;
        link_ph     = LINK_IDLE;
        reply_pos   = 0;
        node_q      = NODE_ID_RESET;
        for (int i = 0; i < REPLY_DEPTH; i++)
        begin
            reply_mem[i] = 8'h00;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_node_sweep();
        test_random_traffic();
        test_full_rate();

        if (fails == 0 && expected_tx.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
